@@ design/ryc_pkg.sv @@
// shared constants, types and color conversion functions for the rgb to ycbcr 4:2:0 converter
// no dependencies

package ryc_pkg;

    localparam int MAX_WIDTH_DEFAULT = 4096;
    localparam int HEIGHT_LIMIT      = 8192;
    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    localparam int COMP_W         = 8;
    localparam int SUM_W          = 9;
    localparam int LINE_W         = 3 * SUM_W;
    localparam int FRAME_WIDTH_W  = 13;
    localparam int FRAME_HEIGHT_W = 14;
    localparam int ROW_W          = 13;
    localparam int CFG_DATA_W     = 14;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic KIND_LUMA   = 1'b0;
    localparam logic KIND_CHROMA = 1'b1;

    typedef enum logic [1:0] {
        CM_NONE,
        CM_DIRECT,
        CM_HALF,
        CM_QUAD
    } t_chroma_mode;

    function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [16:0] acc;
        acc = 17'd66 * 17'(r) + 17'd129 * 17'(g) + 17'd25 * 17'(b) + 17'd128;
        return acc[15:8] + 8'd16;
    endfunction

    function automatic logic [7:0] cb_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        logic signed [17:0] acc;
        acc = -18'sd38 * $signed({1'b0, r}) - 18'sd74 * $signed({1'b0, g})
              + 18'sd112 * $signed({1'b0, b}) + 18'sd32896;
        return acc[15:8];
    endfunction

    function automatic logic [7:0] cr_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        logic signed [17:0] acc;
        acc = 18'sd112 * $signed({1'b0, r}) - 18'sd94 * $signed({1'b0, g})
              - 18'sd18 * $signed({1'b0, b}) + 18'sd32896;
        return acc[15:8];
    endfunction

endpackage

@@ design/ryc_ram.sv @@
// generic single-clock ram, one write port and one read port with registered read
// no dependencies

module ryc_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/rgb_to_ycbcr420_converter_top.sv @@
// rgb to bt.601 studio-swing ycbcr 4:2:0 converter, top level
// depends on ryc_pkg and ryc_ram

// Pixels enter in raster order, one per cycle while o_pix_ready is high, and each
// gives a luma result; the bottom-right pixel of every 2x2 block (the last pixel of
// a block clipped by an odd frame size) also gives a chroma pair result right after
// its luma. The even row's horizontal pair sums sit in a line store of
// (MAX_WIDTH+1)/2 entries, written once per pair on even rows but the last and read
// on every accepted pixel through one registered read port, so there is no clearing
// pass after reset. An input transfer reaches the output through the stage 1 and
// stage 2 registers. The output port moves one result per cycle while i_res_ready
// is high, so a pixel that also yields chroma holds the output for its luma and then
// its chroma result. frame_width and frame_height are clamped on write (width
// 1..MAX_WIDTH, height 1..8192) and should be changed only while the block is idle.

module rgb_to_ycbcr420_converter_top #(
    parameter int MAX_WIDTH = ryc_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ryc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [ryc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_pix_valid,
    output logic                               o_pix_ready,
    input  logic [ryc_pkg::COMP_W-1:0]         i_red,
    input  logic [ryc_pkg::COMP_W-1:0]         i_green,
    input  logic [ryc_pkg::COMP_W-1:0]         i_blue,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output logic                               o_kind,
    output logic [ryc_pkg::COMP_W-1:0]         o_luma,
    output logic [ryc_pkg::COMP_W-1:0]         o_blue_diff,
    output logic [ryc_pkg::COMP_W-1:0]         o_red_diff,
    output logic                               o_frame_end
);

    import ryc_pkg::*;

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int CW1        = CW + 1;
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int CMPW       = (WW > FRAME_WIDTH_W) ? WW : FRAME_WIDTH_W;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int WIDTH_RESET_EFF =
        (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;

    // configuration
    logic [WW-1:0]             r_width;
    logic [FRAME_HEIGHT_W-1:0] r_height;
    logic [CMPW-1:0]           cfg_width;
    logic [CMPW-1:0]           n_width;
    logic [FRAME_HEIGHT_W-1:0] n_height;

    // position and left pixel
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COMP_W-1:0] r_left_r;
    logic [COMP_W-1:0] r_left_g;
    logic [COMP_W-1:0] r_left_b;

    // stage 1
    logic              r_s1_valid;
    t_chroma_mode      r_s1_mode;
    logic [COMP_W-1:0] r_s1_luma;
    logic [SUM_W-1:0]  r_s1_sum_r;
    logic [SUM_W-1:0]  r_s1_sum_g;
    logic [SUM_W-1:0]  r_s1_sum_b;
    logic              r_s1_fend;

    // stage 2, output register
    logic              r_s2_valid;
    logic              r_s2_phase;
    logic              r_s2_has_chroma;
    logic [COMP_W-1:0] r_s2_luma;
    logic [COMP_W-1:0] r_s2_cb;
    logic [COMP_W-1:0] r_s2_cr;
    logic              r_s2_fend;

    logic              col_last;
    logic              row_last;
    logic              col_odd;
    logic              row_odd;
    logic              accept;
    logic              s1_free;
    logic              s2_free;
    logic              s2_last;
    logic [SUM_W-1:0]  sum_r;
    logic [SUM_W-1:0]  sum_g;
    logic [SUM_W-1:0]  sum_b;
    t_chroma_mode      n_mode;
    logic [SUM_W-1:0]  n_sum_r;
    logic [SUM_W-1:0]  n_sum_g;
    logic [SUM_W-1:0]  n_sum_b;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_addr;
    logic [LINE_W-1:0] ram_wr_data;
    logic [LINE_W-1:0] ram_rd_data;
    logic [SUM_W-1:0]  ram_r;
    logic [SUM_W-1:0]  ram_g;
    logic [SUM_W-1:0]  ram_b;
    logic [COMP_W-1:0] mean_r;
    logic [COMP_W-1:0] mean_g;
    logic [COMP_W-1:0] mean_b;
    logic [SUM_W:0]    quad_r;
    logic [SUM_W:0]    quad_g;
    logic [SUM_W:0]    quad_b;

    // handshake
    assign s2_last     = !r_s2_has_chroma || r_s2_phase;
    assign s2_free     = !r_s2_valid || (i_res_ready && s2_last);
    assign s1_free     = !r_s1_valid || s2_free;
    assign o_pix_ready = s1_free;
    assign accept      = i_pix_valid && s1_free;

    // config clamp
    always_comb begin
        cfg_width = CMPW'(i_cfg_data[FRAME_WIDTH_W-1:0]);
        n_width   = cfg_width;
        if (cfg_width == '0) begin
            n_width = CMPW'(1);
        end else if (cfg_width > CMPW'(MAX_WIDTH)) begin
            n_width = CMPW'(MAX_WIDTH);
        end
        n_height = i_cfg_data[FRAME_HEIGHT_W-1:0];
        if (n_height == '0) begin
            n_height = FRAME_HEIGHT_W'(1);
        end else if (n_height > FRAME_HEIGHT_W'(HEIGHT_LIMIT)) begin
            n_height = FRAME_HEIGHT_W'(HEIGHT_LIMIT);
        end
    end

    // input side decode
    assign col_last = ({1'b0, r_col} + CW1'(1)) >= CW1'(r_width);
    assign row_last = ({1'b0, r_row} + FRAME_HEIGHT_W'(1)) >= r_height;
    assign col_odd  = r_col[0];
    assign row_odd  = r_row[0];
    assign sum_r    = {1'b0, r_left_r} + {1'b0, i_red};
    assign sum_g    = {1'b0, r_left_g} + {1'b0, i_green};
    assign sum_b    = {1'b0, r_left_b} + {1'b0, i_blue};

    always_comb begin
        n_mode  = CM_NONE;
        n_sum_r = sum_r;
        n_sum_g = sum_g;
        n_sum_b = sum_b;
        if (!col_odd) begin
            n_sum_r = {1'b0, i_red};
            n_sum_g = {1'b0, i_green};
            n_sum_b = {1'b0, i_blue};
            if (!row_odd && row_last) begin
                if (col_last) begin
                    n_mode = CM_DIRECT;
                end
            end else if (row_odd && col_last) begin
                n_mode = CM_HALF;
            end
        end else begin
            if (!row_odd && row_last) begin
                n_mode  = CM_DIRECT;
                n_sum_r = {1'b0, sum_r[SUM_W-1:1]};
                n_sum_g = {1'b0, sum_g[SUM_W-1:1]};
                n_sum_b = {1'b0, sum_b[SUM_W-1:1]};
            end else if (row_odd) begin
                n_mode = CM_QUAD;
            end
        end
    end

    // line store of even-row pair sums
    assign ram_addr    = AW'(r_col >> 1);
    assign ram_wr_en   = accept && !row_odd && !row_last && (col_odd || col_last);
    assign ram_wr_data = col_odd ? {sum_r, sum_g, sum_b}
                                 : {i_red, 1'b0, i_green, 1'b0, i_blue, 1'b0};

    ryc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_rd_data)
    );

    // stage 1 chroma means
    assign ram_r  = ram_rd_data[3*SUM_W-1:2*SUM_W];
    assign ram_g  = ram_rd_data[2*SUM_W-1:SUM_W];
    assign ram_b  = ram_rd_data[SUM_W-1:0];
    assign quad_r = {1'b0, ram_r} + {1'b0, r_s1_sum_r};
    assign quad_g = {1'b0, ram_g} + {1'b0, r_s1_sum_g};
    assign quad_b = {1'b0, ram_b} + {1'b0, r_s1_sum_b};

    always_comb begin
        unique case (r_s1_mode)
            CM_DIRECT: begin
                mean_r = r_s1_sum_r[COMP_W-1:0];
                mean_g = r_s1_sum_g[COMP_W-1:0];
                mean_b = r_s1_sum_b[COMP_W-1:0];
            end
            CM_HALF: begin
                mean_r = ram_r[SUM_W-1:1];
                mean_g = ram_g[SUM_W-1:1];
                mean_b = ram_b[SUM_W-1:1];
            end
            CM_QUAD: begin
                mean_r = quad_r[SUM_W:2];
                mean_g = quad_g[SUM_W:2];
                mean_b = quad_b[SUM_W:2];
            end
            default: begin
                mean_r = '0;
                mean_g = '0;
                mean_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(WIDTH_RESET_EFF);
            r_height   <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET);
            r_col      <= '0;
            r_row      <= '0;
            r_left_r   <= '0;
            r_left_g   <= '0;
            r_left_b   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_phase <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_width  <= WW'(n_width);
                    CFG_FRAME_HEIGHT: r_height <= n_height;
                    default: ;
                endcase
            end

            if (accept) begin
                if (col_last) begin
                    r_col <= '0;
                    if (row_last) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
                if (!col_odd) begin
                    r_left_r <= i_red;
                    r_left_g <= i_green;
                    r_left_b <= i_blue;
                end
            end

            if (s1_free) begin
                r_s1_valid <= i_pix_valid;
            end

            if (r_s2_valid && i_res_ready && !s2_last) begin
                r_s2_phase <= 1'b1;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
                r_s2_phase <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode  <= n_mode;
            r_s1_luma  <= luma_of(i_red, i_green, i_blue);
            r_s1_sum_r <= n_sum_r;
            r_s1_sum_g <= n_sum_g;
            r_s1_sum_b <= n_sum_b;
            r_s1_fend  <= col_last && row_last;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_has_chroma <= (r_s1_mode != CM_NONE);
            r_s2_luma       <= r_s1_luma;
            r_s2_cb         <= cb_of(mean_r, mean_g, mean_b);
            r_s2_cr         <= cr_of(mean_r, mean_g, mean_b);
            r_s2_fend       <= r_s1_fend;
        end
    end

    // output transfer
    assign o_res_valid = r_s2_valid;
    assign o_kind      = r_s2_phase ? KIND_CHROMA : KIND_LUMA;
    assign o_luma      = r_s2_phase ? '0 : r_s2_luma;
    assign o_blue_diff = r_s2_phase ? r_s2_cb : '0;
    assign o_red_diff  = r_s2_phase ? r_s2_cr : '0;
    assign o_frame_end = r_s2_fend && s2_last;

endmodule
